[src/bcce_pkg.sv]
// Package for the block CRC / CBOR engine: constants, frame struct and CRC fold functions.
// No dependencies.
`timescale 1ns / 1ps

package bcce_pkg;

   localparam logic [31:0] CRC32_POLY_REFL = 32'h82F6_3B78;
   localparam logic [15:0] CRC16_POLY_REFL = 16'h8408;
   localparam logic [31:0] CRC_INIT        = 32'hFFFF_FFFF;

   localparam logic [7:0]  CBOR_HDR_BSTR2  = 8'h42;
   localparam logic [7:0]  CBOR_HDR_BSTR4  = 8'h44;

   localparam logic [2:0]  FRAME_LEN16     = 3'd3;
   localparam logic [2:0]  FRAME_LEN32     = 3'd5;

   localparam logic        KIND_CRC16      = 1'b0;
   localparam logic        KIND_CRC32      = 1'b1;

   localparam int          CSR_ADDR_WIDTH  = 3;
   localparam int          CSR_DATA_WIDTH  = 32;
   localparam logic        REG_CRC_KIND    = 1'b0;

   typedef struct packed {
      logic        kind;
      logic [31:0] crc;
   } frame_type;

   function automatic logic [31:0] fold32(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'h0, b};
      for (int i = 0; i < 8; i++) begin
         r = r[0] ? ((r >> 1) ^ CRC32_POLY_REFL) : (r >> 1);
      end
      return r;
   endfunction

   function automatic logic [15:0] fold16(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h0, b};
      for (int i = 0; i < 8; i++) begin
         r = r[0] ? ((r >> 1) ^ CRC16_POLY_REFL) : (r >> 1);
      end
      return r;
   endfunction

   // CRC-16 leaves the upper half of the register untouched
   function automatic logic [31:0] crc_step(input logic kind, input logic [31:0] c,
                                            input logic [7:0] b);
      logic [31:0] r;
      if (kind == KIND_CRC32) begin
         r = fold32(c, b);
      end else begin
         r = {c[31:16], fold16(c[15:0], b)};
      end
      return r;
   endfunction

endpackage

[src/bcce_csr.sv]
// Configuration register file: holds crc_kind behind an APB-style port.
// Depends on bcce_pkg.
`timescale 1ns / 1ps

module bcce_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bcce_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [bcce_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [bcce_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready,
   output logic                                crc_kind
);

   logic crc_kind_ff;
   logic crc_kind_in;
   logic wr_en;
   logic sel_kind;

   assign csr_pready = 1'b1;
   assign sel_kind   = (csr_paddr[bcce_pkg::CSR_ADDR_WIDTH-1] == bcce_pkg::REG_CRC_KIND);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready & sel_kind;

   always_comb begin
      crc_kind_in = crc_kind_ff;
      if (wr_en) begin
         crc_kind_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_kind_ff <= bcce_pkg::KIND_CRC32;
      end else begin
         crc_kind_ff <= crc_kind_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (sel_kind) begin
         csr_prdata[0] = crc_kind_ff;
      end
   end

   assign crc_kind = crc_kind_ff;

endmodule

[src/bcce_crc_core.sv]
// Input register and running CRC register; hands a finished CRC to the framer.
// Depends on bcce_pkg.
`timescale 1ns / 1ps

module bcce_crc_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                crc_kind,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   input  logic                req_tlast,
   input  logic                frame_free,
   output logic                frame_load,
   output bcce_pkg::frame_type frame
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff, in_byte_in;
   logic        in_eob_ff, in_eob_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] crc_next;
   logic        advance;
   logic        take;

   assign crc_next   = bcce_pkg::crc_step(crc_kind, crc_ff, in_byte_ff);
   assign advance    = in_valid_ff & (~in_eob_ff | frame_free);
   assign req_tready = ~in_valid_ff | advance;
   assign take       = req_tvalid & req_tready;

   assign frame_load = advance & in_eob_ff;
   assign frame.kind = crc_kind;
   assign frame.crc  = ~crc_next;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_eob_in   = in_eob_ff;
      crc_in      = crc_ff;
      if (advance) begin
         in_valid_in = 1'b0;
         crc_in      = in_eob_ff ? bcce_pkg::CRC_INIT : crc_next;
      end
      if (take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
         in_eob_in   = req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         crc_ff      <= bcce_pkg::CRC_INIT;
      end else begin
         in_valid_ff <= in_valid_in;
         crc_ff      <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_eob_ff  <= in_eob_in;
   end

endmodule

[src/bcce_frame_out.sv]
// CBOR byte-string framer: holds one encoded CRC and sends it a byte per beat.
// Depends on bcce_pkg.
`timescale 1ns / 1ps

module bcce_frame_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                frame_load,
   input  bcce_pkg::frame_type frame,
   output logic                frame_free,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,
   output logic                rsp_tlast
);

   logic [39:0] shift_ff, shift_in;
   logic [2:0]  count_ff, count_in;
   logic        beat;

   assign rsp_tvalid = (count_ff != 3'd0);
   assign rsp_tdata  = shift_ff[39:32];
   assign rsp_tlast  = (count_ff == 3'd1);
   assign beat       = rsp_tvalid & rsp_tready;
   assign frame_free = (count_ff == 3'd0) | (rsp_tlast & rsp_tready);

   always_comb begin
      shift_in = shift_ff;
      count_in = count_ff;
      if (beat) begin
         shift_in = {shift_ff[31:0], 8'h00};
         count_in = count_ff - 3'd1;
      end
      if (frame_load) begin
         if (frame.kind == bcce_pkg::KIND_CRC32) begin
            shift_in = {bcce_pkg::CBOR_HDR_BSTR4, frame.crc};
            count_in = bcce_pkg::FRAME_LEN32;
         end else begin
            shift_in = {bcce_pkg::CBOR_HDR_BSTR2, frame.crc[15:0], 16'h0000};
            count_in = bcce_pkg::FRAME_LEN16;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
   end

endmodule

[src/block_crc_cbor_engine_top.sv]
// Block CRC / CBOR engine: running CRC-32C or CRC-16/X25 over a byte stream,
// each block closed by its CRC as a CBOR byte string.
// Usage:
//   req_ channel: one data byte per beat, tlast on the final byte of a block.
//   rsp_ channel: per block, header 0x44 and four CRC bytes (CRC-32C) or header
//   0x42 and two CRC bytes (CRC-16/X25), most significant first; tlast on the
//   final CRC byte. Non-final bytes give no output.
//   csr_ port: register 0 at address 0, bit 0 = crc_kind (1 CRC-32C, 0 CRC-16);
//   write it only while the engine is idle.
// Timing:
//   One byte per cycle is taken while req_ is not stalled. The final byte of a
//   block passes through the input register into the framer's shift register,
//   which offers the header byte on rsp_, then one byte per cycle while
//   rsp_tready is high. The framer holds one encoded CRC; a further final byte
//   waits in the input register until that frame's last beat is taken, stalling
//   req_ there. Non-final bytes keep flowing while a frame drains.
// Reset (synchronous, active high): CRC register to all ones, crc_kind to
//   CRC-32C, no bytes held or pending.
`timescale 1ns / 1ps

module block_crc_cbor_engine_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // data_byte
   input  logic                                req_tlast,   // end_of_block
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [7:0]                          rsp_tdata,   // out_byte
   output logic                                rsp_tlast,   // last_out
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bcce_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [bcce_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [bcce_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready
);

   logic                crc_kind;
   logic                frame_free;
   logic                frame_load;
   bcce_pkg::frame_type frame;

   bcce_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .crc_kind    (crc_kind)
   );

   bcce_crc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .crc_kind   (crc_kind),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .frame_free (frame_free),
      .frame_load (frame_load),
      .frame      (frame)
   );

   bcce_frame_out u_out (
      .clock      (clock),
      .reset      (reset),
      .frame_load (frame_load),
      .frame      (frame),
      .frame_free (frame_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
